### src/sensor_event_parser_status_defines.svh
// ----------------------------------------------------------------------------
// Sensor event parser assertion macros
// Assertion wrappers shared by the sensor event parser; they reduce to
// nothing when the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef SENSOR_EVENT_PARSER_STATUS_DEFINES_SVH
`define SENSOR_EVENT_PARSER_STATUS_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define SEP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define SEP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SEP_ASSERT(label, prop, msg)
`define SEP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### src/sep_pkg.sv
// ----------------------------------------------------------------------------
// Sensor event parser package
// Constants, codes and types used by the sensor event parser.
// ----------------------------------------------------------------------------
package sep_pkg;

    // Sensor slots and the payload window.
    localparam int SENSOR_SLOTS  = 2;
    localparam int SENSOR_W      = 1;
    localparam int PAYLOAD_LIMIT = 48;
    localparam int POS_W         = 6;
    localparam int NUM_W         = 32;

    localparam logic [POS_W-1:0] POS_END = POS_W'(PAYLOAD_LIMIT - 1);

    // Length of the word that marks an open sensor.
    localparam logic [2:0] OPEN_LEN = 3'd4;

    // Characters the parser looks for.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Input transaction kinds.
    typedef enum logic [1:0] {
        ACT_BYTE      = 2'd0,
        ACT_LINK_UP   = 2'd1,
        ACT_LINK_LOST = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    // Result kinds.
    typedef enum logic [1:0] {
        RES_EVENT     = 2'd0,
        RES_MALFORMED = 2'd1,
        RES_LINK      = 2'd2
    } result_kind_t;

    // Room colour codes.
    typedef enum logic [1:0] {
        COL_YELLOW = 2'd0,
        COL_RED    = 2'd1,
        COL_GREEN  = 2'd2
    } colour_t;

    // Parser phases.
    typedef enum logic [5:0] {
        PH_NAME   = 6'b000001,
        PH_STATE  = 6'b000010,
        PH_SPACE  = 6'b000100,
        PH_SIGN   = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // One character of the open word, by position.
    function automatic logic [7:0] open_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0: ch = 8'h4F;
            2'd1: ch = 8'h50;
            2'd2: ch = 8'h45;
            2'd3: ch = 8'h4E;
            default: ch = 8'h4F;
        endcase
        return ch;
    endfunction

endpackage

### src/sensor_event_parser_status.sv
// ----------------------------------------------------------------------------
// Sensor event parser and room status
// Parses ID:STATE:seq notifications byte by byte, tracks per-sensor sequence
// numbers, open flags and link state, and reports the room colour.
// ----------------------------------------------------------------------------
// The block takes one input transaction in every cycle that s_tready is high:
// each payload byte or link event is processed in a single registered pass, and
// the result of the transaction that produces one (the final byte of a payload
// or a link event) appears on the master side in the next cycle. The only
// pipeline stage is the output register, so s_tready is low only while that
// register holds a result that the downstream side has not taken; sustained
// throughput is one transaction per clock. Payload bytes of both sensors share
// one parser, and the result belongs to the sensor named with the final byte.
`include "sensor_event_parser_status_defines.svh"

module sensor_event_parser_status (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] sensor_index, [8:1] data_byte, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        s_tlast,   // last_byte
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] source_sensor, [1] opened,
                                   // [33:2] event_number, [65:34] lost_count,
                                   // [67:66] room_colour, rest zero
    output logic [1:0]  m_tuser    // [1:0] result_kind
);
    import sep_pkg::*;

    // Input field decode
    logic                s_fire;
    action_t             act;
    logic [SENSOR_W-1:0] idx;
    logic [7:0]          ch;
    logic                slot_ok;

    assign s_fire  = s_tvalid && s_tready;
    assign act     = action_t'(s_tuser);
    assign idx     = s_tdata[SENSOR_W-1:0];
    assign ch      = s_tdata[8:1];
    assign slot_ok = (32'(idx) < 32'(SENSOR_SLOTS));

    // Parser and sensor state
    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [2:0]       match_cnt_reg, match_cnt_next;
    logic             match_ok_reg, match_ok_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             sat_reg, sat_next;
    logic [NUM_W-1:0] prev_reg [SENSOR_SLOTS];
    logic [NUM_W-1:0] prev_next [SENSOR_SLOTS];
    logic [SENSOR_SLOTS-1:0] open_reg, open_next;
    logic [SENSOR_SLOTS-1:0] link_reg, link_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    result_kind_t     kind_reg, kind_next;
    logic             src_reg, src_next;
    logic             opened_reg, opened_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] lost_reg, lost_next;
    colour_t          colour_reg, colour_next;

    // Working values of the single pass
    logic             is_digit;
    logic             is_space;
    logic [3:0]       digit;
    logic [35:0]      prod;
    logic             emit;
    logic [NUM_W-1:0] seq;
    logic [NUM_W-1:0] prev_sel;
    logic             opened_now;
    logic             any_lost;
    logic             any_open;

    assign s_tready = !m_valid_reg || m_tready;

    // Character classes and the decimal step (x * 8 + x * 2 + digit).
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign digit    = 4'(ch - CH_ZERO);
    assign prod     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {32'b0, digit};

    // Next state of parser, sensor flags and output register.
    always_comb begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        match_cnt_next = match_cnt_reg;
        match_ok_next  = match_ok_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        prev_next      = prev_reg;
        open_next      = open_reg;
        link_next      = link_reg;
        emit           = 1'b0;
        kind_next      = kind_reg;
        src_next       = src_reg;
        opened_next    = opened_reg;
        num_next       = num_reg;
        lost_next      = lost_reg;
        seq            = '0;
        prev_sel       = prev_reg[idx];
        opened_now     = 1'b0;

        if (s_fire && slot_ok) begin
            if ((act == ACT_LINK_UP) || (act == ACT_LINK_LOST)) begin
                // Link change: update the flag and report it.
                link_next[idx] = (act == ACT_LINK_UP);
                emit           = 1'b1;
                kind_next      = RES_LINK;
                src_next       = idx;
                opened_next    = 1'b0;
                num_next       = '0;
                lost_next      = '0;
            end else if (act == ACT_BYTE) begin
                // Take the byte if it is still inside the payload window.
                if (pos_reg < POS_END) begin
                    if (ch == CH_NUL) begin
                        pos_next = POS_END;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                        if ((phase_reg != PH_NAME) && (match_cnt_reg < OPEN_LEN)) begin
                            if (ch != open_char(match_cnt_reg[1:0])) begin
                                match_ok_next = 1'b0;
                            end
                            match_cnt_next = match_cnt_reg + 1'b1;
                        end
                        unique case (phase_reg)
                            PH_NAME: begin
                                if (ch == CH_COLON) phase_next = PH_STATE;
                            end
                            PH_STATE: begin
                                if (ch == CH_COLON) phase_next = PH_SPACE;
                            end
                            PH_SPACE, PH_SIGN, PH_DIGITS: begin
                                if (is_digit) begin
                                    if (prod[35:32] != 4'd0) begin
                                        sat_next = 1'b1;
                                        acc_next = '1;
                                    end else begin
                                        acc_next = prod[31:0];
                                    end
                                    phase_next = PH_DIGITS;
                                end else if ((phase_reg == PH_SPACE) && is_space) begin
                                    phase_next = PH_SPACE;
                                end else if ((phase_reg == PH_SPACE) &&
                                             ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
                                    neg_next   = (ch == CH_MINUS);
                                    phase_next = PH_SIGN;
                                end else begin
                                    phase_next = PH_DONE;
                                end
                            end
                            PH_DONE: begin
                                phase_next = PH_DONE;
                            end
                            default: begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end

                // The final byte closes the payload.
                if (s_tlast) begin
                    emit     = 1'b1;
                    src_next = idx;
                    if ((phase_next == PH_NAME) || (phase_next == PH_STATE)) begin
                        kind_next   = RES_MALFORMED;
                        opened_next = 1'b0;
                        num_next    = '0;
                        lost_next   = '0;
                    end else begin
                        opened_now = match_ok_next && (match_cnt_next == OPEN_LEN);
                        if (sat_next) begin
                            seq = '1;
                        end else if (neg_next) begin
                            seq = NUM_W'(0) - acc_next;
                        end else begin
                            seq = acc_next;
                        end
                        kind_next   = RES_EVENT;
                        opened_next = opened_now;
                        num_next    = seq;
                        if ((prev_sel != '0) &&
                            ({1'b0, seq} > ({1'b0, prev_sel} + 33'd1))) begin
                            lost_next = seq - prev_sel - NUM_W'(1);
                        end else begin
                            lost_next = '0;
                        end
                        prev_next[idx] = seq;
                        open_next[idx] = opened_now;
                    end
                    // Every closed payload starts a fresh parse.
                    pos_next       = '0;
                    phase_next     = PH_NAME;
                    match_cnt_next = '0;
                    match_ok_next  = 1'b1;
                    acc_next       = '0;
                    neg_next       = 1'b0;
                    sat_next       = 1'b0;
                end
            end
        end
    end

    // Room colour after the update: lost link first, then open, then closed.
    always_comb begin
        any_lost = 1'b0;
        any_open = 1'b0;
        for (int i = 0; i < SENSOR_SLOTS; i++) begin
            if (!link_next[i]) any_lost = 1'b1;
            if (open_next[i])  any_open = 1'b1;
        end
        colour_next = colour_reg;
        if (emit) begin
            priority if (any_lost) begin
                colour_next = COL_YELLOW;
            end else if (any_open) begin
                colour_next = COL_RED;
            end else begin
                colour_next = COL_GREEN;
            end
        end
    end

    // Output valid: loaded by a transaction that yields a result.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            phase_reg     <= PH_NAME;
            match_cnt_reg <= '0;
            match_ok_reg  <= 1'b1;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            for (int i = 0; i < SENSOR_SLOTS; i++) begin
                prev_reg[i] <= '0;
            end
            open_reg      <= '0;
            link_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            match_cnt_reg <= match_cnt_next;
            match_ok_reg  <= match_ok_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            sat_reg       <= sat_next;
            prev_reg      <= prev_next;
            open_reg      <= open_next;
            link_reg      <= link_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        src_reg    <= src_next;
        opened_reg <= opened_next;
        num_reg    <= num_next;
        lost_reg   <= lost_next;
        colour_reg <= colour_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {4'b0, colour_reg, lost_reg, num_reg, opened_reg, src_reg};

    // Checks on the parser and the result path
    `SEP_ASSERT(a_pos_window, pos_reg <= POS_END, "byte position beyond payload window")
    `SEP_ASSERT(a_match_len, match_cnt_reg <= OPEN_LEN, "open word match count overran")
    `SEP_ASSERT(a_phase_onehot, $onehot(phase_reg), "parser phase is not one-hot")
    `SEP_ASSERT(a_link_payload,
        (m_valid_reg && (kind_reg == RES_LINK)) |->
            (!opened_reg && (num_reg == '0) && (lost_reg == '0)),
        "link result carries event data")
    `SEP_ASSERT(a_last_yields,
        (s_fire && (act == ACT_BYTE) && s_tlast && slot_ok) |=> m_valid_reg,
        "final payload byte gave no result")

endmodule
